[design/load_store_address_decode_assert.svh]
// ----------------------------------------------------------------------------
// load/store address decode assertion macros
// concurrent checks clocked on i_clk, held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_ADDRESS_DECODE_ASSERT_SVH
`define LOAD_STORE_ADDRESS_DECODE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define LSAD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsad check failed");

// consequent holds in the cycle after the antecedent
`define LSAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsad check failed");

`endif

[design/lsad_pkg.sv]
// ----------------------------------------------------------------------------
// lsad_pkg
// shared types and codes for the load/store address decode block
// ----------------------------------------------------------------------------
package lsad_pkg;

    localparam int XLEN = 64;

    // result status codes
    localparam logic [1:0] ST_ACCESS    = 2'd0;
    localparam logic [1:0] ST_PREFETCH  = 2'd1;
    localparam logic [1:0] ST_UNHANDLED = 2'd2;
    localparam logic [1:0] ST_LIT_WRITE = 2'd3;

    // addressing forms
    localparam logic [1:0] FORM_LIT  = 2'd0;
    localparam logic [1:0] FORM_UIMM = 2'd1;
    localparam logic [1:0] FORM_REG  = 2'd2;
    localparam logic [1:0] FORM_IMM9 = 2'd3;

    localparam logic [4:0] REG_SP = 5'd31;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] size_log2;
        logic       sign_extend;
        logic       is_vector;
        logic [1:0] form;
        logic       wb_en;
        logic       post_index;
    } t_dec_ctrl;

    typedef struct packed {
        logic [1:0]      status;
        logic [XLEN-1:0] address;
        logic [2:0]      size_log2;
        logic [4:0]      target_reg;
        logic            is_vector;
        logic            sign_extend;
        logic            wb_en;
        logic [5:0]      wb_target;
        logic [XLEN-1:0] wb_value;
    } t_res;

endpackage

[design/load_store_address_decode.sv]
// ----------------------------------------------------------------------------
// load_store_address_decode
// decodes one a64 load/store word into address, size, register and writeback
//
//   channel   handshake        payload
//   input     start / busy     i_instruction, i_base_value, i_index_value,
//                              i_pc_value, i_is_write, i_exception_level
//   result    o_done           o_status, o_address, o_size_log2, o_target_reg,
//                              o_is_vector, o_sign_extend, o_writeback_*
//
// one transfer per cycle; busy stays low
// o_done follows the start transfer through the input register, decode and
// one 64-bit adder, and the result register
// synchronous active-low reset clears the stage valid flags only
// results cannot be stalled; o_done is a one-cycle strobe
// ----------------------------------------------------------------------------
module load_store_address_decode
    import lsad_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [31:0]     i_instruction,
    input  logic [XLEN-1:0] i_base_value,
    input  logic [XLEN-1:0] i_index_value,
    input  logic [XLEN-1:0] i_pc_value,
    input  logic            i_is_write,
    input  logic            i_exception_level,
    output logic            o_done,
    output logic [1:0]      o_status,
    output logic [XLEN-1:0] o_address,
    output logic [2:0]      o_size_log2,
    output logic [4:0]      o_target_reg,
    output logic            o_is_vector,
    output logic            o_sign_extend,
    output logic            o_writeback_enable,
    output logic [5:0]      o_writeback_target,
    output logic [XLEN-1:0] o_writeback_value
);

    `include "load_store_address_decode_assert.svh"

    logic            r_in_vld;
    logic [31:0]     r_instr;
    logic [XLEN-1:0] r_base;
    logic [XLEN-1:0] r_index;
    logic [XLEN-1:0] r_pc;
    logic            r_wr;
    logic            r_el;
    logic            r_done;
    t_res            r_res;
    t_res            n_res;
    t_dec_ctrl       ctrl;

    assign busy = 1'b0;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_instr <= i_instruction;
            r_base  <= i_base_value;
            r_index <= i_index_value;
            r_pc    <= i_pc_value;
            r_wr    <= i_is_write;
            r_el    <= i_exception_level;
        end
    end

    lsad_decode u_decode (
        .i_instruction (r_instr),
        .i_is_write    (r_wr),
        .o_ctrl        (ctrl)
    );

    lsad_agen u_agen (
        .i_instruction     (r_instr),
        .i_base_value      (r_base),
        .i_index_value     (r_index),
        .i_pc_value        (r_pc),
        .i_exception_level (r_el),
        .i_ctrl            (ctrl),
        .o_res             (n_res)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_res.status;
    assign o_address          = r_res.address;
    assign o_size_log2        = r_res.size_log2;
    assign o_target_reg       = r_res.target_reg;
    assign o_is_vector        = r_res.is_vector;
    assign o_sign_extend      = r_res.sign_extend;
    assign o_writeback_enable = r_res.wb_en;
    assign o_writeback_target = r_res.wb_target;
    assign o_writeback_value  = r_res.wb_value;

    `LSAD_ASSERT_NEXT(a_start_to_stage, start && !busy, r_in_vld)
    `LSAD_ASSERT_NEXT(a_stage_to_done, r_in_vld, o_done)
    `LSAD_ASSERT_SAME(a_fault_zero, o_done && (o_status != ST_ACCESS),
        (o_address == '0) && !o_writeback_enable && (o_target_reg == '0))
    `LSAD_ASSERT_SAME(a_no_wb_zero, o_done && !o_writeback_enable,
        (o_writeback_target == '0) && (o_writeback_value == '0))
    `LSAD_ASSERT_SAME(a_wb_target_range, o_done, o_writeback_target <= 6'd32)

endmodule

[design/lsad_decode.sv]
// ----------------------------------------------------------------------------
// lsad_decode
// classifies the instruction word: status, access size, sign and form
// ----------------------------------------------------------------------------
module lsad_decode
    import lsad_pkg::*;
(
    input  logic [31:0] i_instruction,
    input  logic        i_is_write,
    output t_dec_ctrl   o_ctrl
);

    logic [1:0] s;
    logic [1:0] opc;
    logic       v;
    logic       prf;
    logic       size_bad;

    assign s   = i_instruction[31:30];
    assign opc = i_instruction[23:22];
    assign v   = i_instruction[26];
    assign prf = !v && (s == 2'd3) && (opc == 2'd2);

    // unallocated size/opc combinations of the register-base forms
    assign size_bad = v ? (opc[1] && (s != 2'd0)) : (s[1] && (opc == 2'd3));

    always_comb begin
        o_ctrl             = '0;
        o_ctrl.status      = ST_ACCESS;
        o_ctrl.is_vector   = v;
        o_ctrl.size_log2   = {1'b0, s};
        o_ctrl.sign_extend = v ? 1'b0 : opc[1];
        o_ctrl.form        = FORM_IMM9;
        if (v && opc[1]) begin
            o_ctrl.size_log2 = 3'd4;
        end
        priority if (!i_instruction[27] || i_instruction[25]) begin
            o_ctrl.status = ST_UNHANDLED;
        end else if (!i_instruction[28] || !i_instruction[29]) begin
            // literal
            o_ctrl.form        = FORM_LIT;
            o_ctrl.size_log2   = v ? ({1'b0, s} + 3'd2) : ({2'b00, s[0]} + 3'd2);
            o_ctrl.sign_extend = v ? 1'b0 : s[1];
            priority if (!i_instruction[28] || i_instruction[29] || i_instruction[24]) begin
                o_ctrl.status = ST_UNHANDLED;
            end else if (i_is_write) begin
                o_ctrl.status = ST_LIT_WRITE;
            end else if (s == 2'd3) begin
                o_ctrl.status = v ? ST_UNHANDLED : ST_PREFETCH;
            end else begin
                o_ctrl.status = ST_ACCESS;
            end
        end else if (size_bad) begin
            o_ctrl.status = ST_UNHANDLED;
        end else if (i_instruction[24]) begin
            o_ctrl.form   = FORM_UIMM;
            o_ctrl.status = prf ? ST_PREFETCH : ST_ACCESS;
        end else if (i_instruction[21]) begin
            o_ctrl.form = FORM_REG;
            priority if ((i_instruction[11:10] != 2'd2) || !i_instruction[14]) begin
                o_ctrl.status = ST_UNHANDLED;
            end else if (prf) begin
                o_ctrl.status = ST_PREFETCH;
            end else begin
                o_ctrl.status = ST_ACCESS;
            end
        end else if (i_instruction[10]) begin
            // pre/post indexed
            o_ctrl.status     = prf ? ST_UNHANDLED : ST_ACCESS;
            o_ctrl.wb_en      = 1'b1;
            o_ctrl.post_index = !i_instruction[11];
        end else begin
            o_ctrl.status = prf ? ST_PREFETCH : ST_ACCESS;
        end
    end

endmodule

[design/lsad_agen.sv]
// ----------------------------------------------------------------------------
// lsad_agen
// offset forming and the single address adder, result field masking
// ----------------------------------------------------------------------------
module lsad_agen
    import lsad_pkg::*;
(
    input  logic [31:0]     i_instruction,
    input  logic [XLEN-1:0] i_base_value,
    input  logic [XLEN-1:0] i_index_value,
    input  logic [XLEN-1:0] i_pc_value,
    input  logic            i_exception_level,
    input  t_dec_ctrl       i_ctrl,
    output t_res            o_res
);

    logic [2:0]      opt;
    logic [XLEN-1:0] ext;
    logic [XLEN-1:0] offset;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] sum;
    logic [4:0]      rn;
    logic            ok;

    assign opt = i_instruction[15:13];
    assign rn  = i_instruction[9:5];
    assign ok  = (i_ctrl.status == ST_ACCESS);

    // uxtw/sxtw or full 64-bit index
    assign ext = opt[0] ? i_index_value
               : {{(XLEN-32){i_index_value[31] & opt[2]}}, i_index_value[31:0]};

    always_comb begin
        unique case (i_ctrl.form)
            FORM_LIT:  offset = {{(XLEN-21){i_instruction[23]}}, i_instruction[23:5], 2'b00};
            FORM_UIMM: offset = {{(XLEN-12){1'b0}}, i_instruction[21:10]} << i_ctrl.size_log2;
            FORM_REG:  offset = i_instruction[12] ? (ext << i_ctrl.size_log2) : ext;
            FORM_IMM9: offset = {{(XLEN-9){i_instruction[20]}}, i_instruction[20:12]};
            default:   offset = '0;
        endcase
    end

    assign op_a = (i_ctrl.form == FORM_LIT) ? i_pc_value : i_base_value;
    assign sum  = op_a + offset;

    always_comb begin
        o_res        = '0;
        o_res.status = i_ctrl.status;
        if (ok) begin
            o_res.address     = i_ctrl.post_index ? i_base_value : sum;
            o_res.size_log2   = i_ctrl.size_log2;
            o_res.target_reg  = i_instruction[4:0];
            o_res.is_vector   = i_ctrl.is_vector;
            o_res.sign_extend = i_ctrl.sign_extend;
            o_res.wb_en       = i_ctrl.wb_en;
            if (i_ctrl.wb_en) begin
                o_res.wb_value  = sum;
                o_res.wb_target = (rn == REG_SP) ? (6'd31 + {5'b0, i_exception_level})
                                                 : {1'b0, rn};
            end
        end
    end

endmodule
